FILE: hdl/mps_pkg.sv
package mps_pkg;

    localparam int QueueDepth = 16;
    localparam int CntW = $clog2(QueueDepth + 1);
    localparam int IdxW = $clog2(QueueDepth);

    localparam logic [1:0] PolFcfs = 2'd0;
    localparam logic [1:0] PolSrt = 2'd1;
    localparam logic [1:0] PolPrio = 2'd2;
    localparam logic [1:0] PolRr = 2'd3;

    localparam logic [1:0] StAccept = 2'd0;
    localparam logic [1:0] StDrop = 2'd1;
    localparam logic [1:0] StRan = 2'd2;
    localparam logic [1:0] StIdle = 2'd3;

    localparam logic CfgPolicy = 1'b0;
    localparam logic CfgSlice = 1'b1;

    typedef struct packed {
        logic [7:0]  ident;
        logic [15:0] remaining;
        logic [15:0] burst;
        logic [7:0]  prio;
        logic [31:0] arrival;
        logic        started;
        logic [31:0] first_start;
    } t_proc;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  run_id;
        logic        finished;
        logic [31:0] end_tick;
        logic [31:0] turnaround;
        logic [31:0] waiting;
        logic [31:0] response;
        logic [31:0] time_now;
    } t_result;

    typedef struct packed {
        logic        req_type;
        logic [7:0]  proc_id;
        logic [15:0] burst_length;
        logic [7:0]  priority_level;
    } t_req;

endpackage

FILE: hdl/mps_stream_if.sv
interface mps_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/mps_cell.sv
module mps_cell
    import mps_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_shift,
    input  logic  i_load,
    input  t_proc i_load_data,
    input  t_proc i_next,
    output t_proc o_entry
);
    t_proc r_entry;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_entry <= i_load_data;
        end else if (i_shift) begin
            r_entry <= i_next;
        end
    end

    assign o_entry = r_entry;
endmodule

FILE: hdl/multi_policy_cpu_scheduler_top.sv
// An arrival's result is registered with its beat, or after the S_OUT requeue when it
// preempts; a tick passes through S_RUN with a process running, and through selection and
// S_RUN when it must select. SRT and priority selection scans the cell row one entry per
// cycle, then the row behind the pick shifts down one cell. Input waits for the result beat
// to be taken. Reset (synchronous, active low) clears counters, the running flag and policy
// registers; queue cells hold no reset and are read only after being written.
module multi_policy_cpu_scheduler_top
    import mps_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    mps_stream_if.sink   s_in,
    mps_stream_if.source m_out
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_SHIFT = 5'b00100,
        S_RUN   = 5'b01000,
        S_OUT   = 5'b10000
    } t_state;

    t_state r_state;
    logic [1:0] r_policy;
    logic [7:0] r_slice_cfg;
    logic [31:0] r_time;
    logic [CntW-1:0] r_count;
    logic r_run_valid;
    t_proc r_run;
    logic [7:0] r_slice_left;
    logic [IdxW-1:0] r_scan;
    logic [15:0] r_best_key;
    logic [IdxW-1:0] r_shpos;
    t_result r_res;
    logic r_out_valid;

    t_proc cell_q [QueueDepth];
    logic [QueueDepth-1:0] cell_shift;
    logic [QueueDepth-1:0] cell_load;
    t_proc load_data;
    t_req req;

    assign req = s_in.data;
    assign s_in.ready = (r_state == S_IDLE) && !r_out_valid;
    assign m_out.valid = r_out_valid;
    assign m_out.data = r_res;

    genvar g;
    generate
        for (g = 0; g < QueueDepth; g++) begin : g_cell
            mps_cell u_cell (
                .i_clk       (i_clk),
                .i_shift     (cell_shift[g]),
                .i_load      (cell_load[g]),
                .i_load_data (load_data),
                .i_next      ((g == QueueDepth - 1) ? cell_q[g] : cell_q[(g + 1) % QueueDepth]),
                .o_entry     (cell_q[g])
            );
        end
    endgenerate

    logic [15:0] scan_key;
    always_comb begin
        scan_key = (r_policy == PolSrt) ? cell_q[r_scan].remaining
                                        : {8'd0, cell_q[r_scan].prio};
    end

    logic accept;
    assign accept = s_in.valid && s_in.ready;
    logic [IdxW-1:0] push_idx;
    assign push_idx = r_count[IdxW-1:0];

    t_proc arr;
    always_comb begin
        arr.ident = req.proc_id;
        arr.remaining = req.burst_length;
        arr.burst = req.burst_length;
        arr.prio = req.priority_level;
        arr.arrival = r_time;
        arr.started = 1'b0;
        arr.first_start = '0;
    end

    // Running process state after this tick's unit of work.
    t_proc ran;
    logic [7:0] slice_after;
    always_comb begin
        ran = r_run;
        if (!ran.started) begin
            ran.started = 1'b1;
            ran.first_start = r_time;
        end
        if (ran.remaining != 16'd0) ran.remaining = ran.remaining - 16'd1;
        slice_after = (r_policy == PolRr) ? r_slice_left - 8'd1 : r_slice_left;
    end

    t_result run_res;
    always_comb begin
        run_res = '0;
        run_res.status = StRan;
        run_res.run_id = r_run.ident;
        run_res.time_now = r_time;
        if (ran.remaining == 16'd0) begin
            run_res.finished = 1'b1;
            run_res.end_tick = r_time + 32'd1;
            run_res.turnaround = r_time + 32'd1 - ran.arrival;
            run_res.waiting = r_time + 32'd1 - ran.arrival - {16'd0, ran.burst};
            run_res.response = ran.first_start - ran.arrival;
        end
    end

    t_result idle_res;
    always_comb begin
        idle_res = '0;
        idle_res.time_now = r_time;
        if (!req.req_type) begin
            idle_res.status = (r_count >= CntW'(QueueDepth)) ? StDrop : StAccept;
        end else begin
            idle_res.status = StIdle;
        end
    end

    logic preempt;
    assign preempt = (r_policy == PolPrio) && r_run_valid && (arr.prio < r_run.prio)
                     && ({1'b0, r_count} + 1'b1 < (CntW + 1)'(QueueDepth));

    always_comb begin
        cell_load = '0;
        cell_shift = '0;
        load_data = arr;
        if (r_state == S_IDLE && accept && !req.req_type
            && r_count < CntW'(QueueDepth)) begin
            cell_load[push_idx] = 1'b1;
        end
        if (r_state == S_OUT && r_count < CntW'(QueueDepth)) begin
            load_data = r_run;
            cell_load[push_idx] = 1'b1;
        end
        if (r_state == S_SHIFT) begin
            for (int k = 0; k < QueueDepth; k++)
                if (IdxW'(k) >= r_shpos) cell_shift[k] = 1'b1;
        end
    end

    // S_OUT here requeues the running process (preempted or slice expired).
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_policy <= PolFcfs;
            r_slice_cfg <= 8'd2;
            r_time <= '0;
            r_count <= '0;
            r_run_valid <= 1'b0;
            r_slice_left <= '0;
            r_out_valid <= 1'b0;
            r_scan <= '0;
            r_shpos <= '0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CfgPolicy) r_policy <= i_cfg_data[1:0];
                else r_slice_cfg <= i_cfg_data;
            end
            if (m_out.valid && m_out.ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_res <= idle_res;
                        if (!req.req_type) begin
                            if (r_count >= CntW'(QueueDepth)) begin
                                r_out_valid <= 1'b1;
                            end else begin
                                r_count <= r_count + 1'b1;
                                if (preempt) begin
                                    r_state <= S_OUT;
                                end else begin
                                    r_out_valid <= 1'b1;
                                end
                            end
                        end else if (r_run_valid) begin
                            r_state <= S_RUN;
                        end else if (r_count == '0) begin
                            r_time <= r_time + 32'd1;
                            r_out_valid <= 1'b1;
                        end else begin
                            r_scan <= '0;
                            r_best_key <= 16'hffff;
                            r_state <= (r_policy == PolSrt || r_policy == PolPrio)
                                       ? S_SCAN : S_SHIFT;
                            r_shpos <= '0;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_scan == '0 || scan_key < r_best_key) begin
                        r_best_key <= scan_key;
                        r_shpos <= r_scan;
                    end
                    if (CntW'({1'b0, r_scan}) + CntW'(1) >= r_count) begin
                        r_state <= S_SHIFT;
                    end
                    r_scan <= r_scan + 1'b1;
                end
                S_SHIFT: begin
                    r_run <= cell_q[r_shpos];
                    r_run_valid <= 1'b1;
                    r_slice_left <= r_slice_cfg;
                    r_count <= r_count - 1'b1;
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    r_res <= run_res;
                    r_time <= r_time + 32'd1;
                    r_run <= ran;
                    if (ran.remaining == 16'd0) begin
                        r_slice_left <= slice_after;
                        r_run_valid <= 1'b0;
                        r_out_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (r_policy == PolRr && slice_after == 8'd0
                                 && r_count < CntW'(QueueDepth)) begin
                        r_slice_left <= slice_after;
                        r_state <= S_OUT;
                    end else if (r_policy == PolRr && slice_after == 8'd0) begin
                        r_slice_left <= r_slice_cfg;
                        r_out_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_slice_left <= slice_after;
                        r_out_valid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                S_OUT: begin
                    r_count <= r_count + 1'b1;
                    r_run_valid <= 1'b0;
                    r_out_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CntW'(QueueDepth)) else $error("queue count over depth");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in.ready |-> (r_state == S_IDLE)) else $error("ready outside idle");
    a_run_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> r_run_valid) else $error("run without process");
endmodule
